// ===== rtl/lzc_pkg.sv =====
// ----------------------------------------------------------------------------
// lzc_pkg: shared types for the Lempel-Ziv complexity block
// Controller states and the command/status groups passed between the
// controller and the datapath, plus the fixed port widths.
// ----------------------------------------------------------------------------
package lzc_pkg;

  // Fixed field widths of the ports
  localparam int SYMBOL_IN_W  = 8;
  localparam int COMPLEXITY_W = 13;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // store one symbol (or flag overflow when full)
    logic init;   // set up the phrase search
    logic step;   // evaluate one comparison of the search
    logic clear;  // drop the finished sequence
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic short_seq;  // stored sequence has at most one symbol
    logic finish;     // current comparison ends the search
  } status_t;

endpackage

// ===== rtl/lzc_ram.sv =====
// ----------------------------------------------------------------------------
// lzc_ram: generic RAM, one write port, two registered read ports
// Write and both reads happen in the same cycle; read data is registered
// and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module lzc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/lzc_datapath.sv =====
// ----------------------------------------------------------------------------
// lzc_datapath: symbol store and phrase search registers
// Holds the sequence, its length and overflow flag, and the search
// positions p, q, run, best together with the phrase count.
// ----------------------------------------------------------------------------
module lzc_datapath #(
  parameter int MAX_LEN     = 4096,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lzc_pkg::cmd_t                         cmd,
  input  logic [lzc_pkg::SYMBOL_IN_W-1:0]       symbol,
  output lzc_pkg::status_t                      status,
  output logic [lzc_pkg::COMPLEXITY_W-1:0]      complexity,
  output logic                                  overflow
);

  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int EXT_W  = lzc_pkg::SYMBOL_IN_W + 16;

  logic [LEN_W-1:0] len;
  logic             ovf;
  logic [LEN_W-1:0] p;
  logic [LEN_W-1:0] q;
  logic [LEN_W-1:0] run;
  logic [LEN_W-1:0] best;
  logic [LEN_W-1:0] count;

  logic [EXT_W-1:0]       sym_ext;
  logic [SYMBOL_BITS-1:0] wsym;
  logic                   room;
  logic [LEN_W-1:0]       addr_a;
  logic [LEN_W-1:0]       addr_b;
  logic [SYMBOL_BITS-1:0] rd_a;
  logic [SYMBOL_BITS-1:0] rd_b;
  logic                   equal;
  logic [LEN_W-1:0]       run_next;
  logic [LEN_W-1:0]       best_next;
  logic [LEN_W-1:0]       p_next;
  logic                   last_q;
  logic                   match_end;
  logic [LEN_W+lzc_pkg::COMPLEXITY_W-1:0] count_ext;

  // Keep the low symbol bits
  assign sym_ext = {16'd0, symbol};
  assign wsym    = sym_ext[SYMBOL_BITS-1:0];
  assign room    = (len < LEN_W'(MAX_LEN));

  // Compare addresses: earlier start and current phrase
  assign addr_a = q + run;
  assign addr_b = p + run;

  lzc_ram #(
    .WIDTH (SYMBOL_BITS),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk     (clk),
    .we      (cmd.load && room),
    .waddr   (len[ADDR_W-1:0]),
    .wdata   (wsym),
    .raddr_a (addr_a[ADDR_W-1:0]),
    .rdata_a (rd_a),
    .raddr_b (addr_b[ADDR_W-1:0]),
    .rdata_b (rd_b)
  );

  // Search step terms
  assign equal     = (rd_a == rd_b);
  assign run_next  = run + LEN_W'(1);
  assign best_next = (run > best) ? run : best;
  assign p_next    = p + best_next + LEN_W'(1);
  assign last_q    = ((q + LEN_W'(1)) == p);
  assign match_end = ((p + run_next) >= len);

  assign status.short_seq = (len <= LEN_W'(1));
  assign status.finish    = equal ? match_end : (last_q && (p_next >= len));

  // Sequence length and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      ovf <= 1'b0;
    end else if (cmd.load) begin
      if (room) begin
        len <= len + LEN_W'(1);
      end else begin
        ovf <= 1'b1;
      end
    end else if (cmd.clear) begin
      len <= '0;
      ovf <= 1'b0;
    end
  end

  // Phrase search registers
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      count <= LEN_W'(1);
      p     <= LEN_W'(1);
      q     <= '0;
      run   <= '0;
      best  <= '0;
    end else if (cmd.step) begin
      if (equal) begin
        run <= run_next;
        if (match_end) begin
          count <= count + LEN_W'(1);
        end
      end else if (last_q) begin
        // close the phrase one symbol past the longest match
        count <= count + LEN_W'(1);
        p     <= p_next;
        q     <= '0;
        run   <= '0;
        best  <= '0;
      end else begin
        best <= best_next;
        run  <= '0;
        q    <= q + LEN_W'(1);
      end
    end
  end

  assign count_ext  = {{lzc_pkg::COMPLEXITY_W{1'b0}}, count};
  assign complexity = count_ext[lzc_pkg::COMPLEXITY_W-1:0];
  assign overflow   = ovf;

endmodule

// ===== rtl/lzc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lzc_ctrl: controller for the Lempel-Ziv complexity block
// Accepts symbols while idle, then sequences the phrase search as
// read/compare pairs and strobes the result for one cycle.
// ----------------------------------------------------------------------------
module lzc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              last_symbol,
  input  lzc_pkg::status_t  status,
  output lzc_pkg::cmd_t     cmd,
  output logic              busy,
  output logic              valid
);

  lzc_pkg::state_t state;
  lzc_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    valid      = 1'b0;
    case (state)
      lzc_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (last_symbol) begin
            state_next = lzc_pkg::ST_INIT;
          end
        end
      end
      lzc_pkg::ST_INIT: begin
        cmd.init = 1'b1;
        state_next = status.short_seq ? lzc_pkg::ST_DONE : lzc_pkg::ST_READ;
      end
      lzc_pkg::ST_READ: begin
        // wait for the registered store reads
        state_next = lzc_pkg::ST_CMP;
      end
      lzc_pkg::ST_CMP: begin
        cmd.step = 1'b1;
        state_next = status.finish ? lzc_pkg::ST_DONE : lzc_pkg::ST_READ;
      end
      lzc_pkg::ST_DONE: begin
        valid      = 1'b1;
        cmd.clear  = 1'b1;
        state_next = lzc_pkg::ST_IDLE;
      end
      default: begin
        state_next = lzc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/lempel_ziv_complexity_top.sv =====
// ----------------------------------------------------------------------------
// lempel_ziv_complexity_top: LZ76 phrase count of a byte sequence
// Stores symbols one per transaction; after the last one, counts the
// phrases by longest-match search over all earlier start positions.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------
//  input    | start & !busy           | symbol[7:0], last_symbol
//  result   | valid (one-cycle pulse) | complexity[12:0], overflow
//
//  Busy stays low while symbols are loading. After the last symbol the
//  block runs a setup state, then each comparison of the search as a store
//  read followed by a compare, then a result state. The comparison count
//  grows roughly with the square of the sequence length; the registered
//  read ports of the dual-read store require the separate read step.
//  Synchronous reset returns to idle with an empty sequence; the receiver
//  cannot stall, so the result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module lempel_ziv_complexity_top #(
  parameter int MAX_LEN     = 4096,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [lzc_pkg::SYMBOL_IN_W-1:0]      symbol,
  input  logic                                 last_symbol,
  output logic                                 valid,
  output logic [lzc_pkg::COMPLEXITY_W-1:0]     complexity,
  output logic                                 overflow
);

  lzc_pkg::cmd_t    cmd;
  lzc_pkg::status_t status;

  lzc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .last_symbol (last_symbol),
    .status      (status),
    .cmd         (cmd),
    .busy        (busy),
    .valid       (valid)
  );

  lzc_datapath #(
    .MAX_LEN     (MAX_LEN),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .symbol     (symbol),
    .status     (status),
    .complexity (complexity),
    .overflow   (overflow)
  );

endmodule
